// ===== design/cau_pkg.sv =====
// Package: types, constants and saturation helpers for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

  localparam int FRAC_BITS = 8;
  localparam int QW        = 16;
  localparam int NUM_W     = 32 + FRAC_BITS;
  localparam int REM_W     = (NUM_W > 32 + QW) ? NUM_W : 32 + QW;

  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  localparam logic signed [15:0] RES_MAX = 16'sh7fff;
  localparam logic signed [15:0] RES_MIN = -16'sh8000;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               div_zero;
    logic               overflow;
  } cau_out_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    q;
  } cau_lane_t;

  typedef struct packed {
    logic [1:0] func;
    cau_out_t   alt;
    logic       dz;
    logic       neg_re;
    logic       neg_im;
    logic       pov_re;
    logic       pov_im;
  } cau_side_t;

  typedef struct packed {
    logic [15:0] v;
    logic        o;
  } cau_sat_t;

  function automatic cau_sat_t sat34(input logic signed [33:0] x);
    cau_sat_t r;
    if (x > 34'(RES_MAX)) begin
      r.v = RES_MAX;
      r.o = 1'b1;
    end else if (x < 34'(RES_MIN)) begin
      r.v = RES_MIN;
      r.o = 1'b1;
    end else begin
      r.v = x[15:0];
      r.o = 1'b0;
    end
    return r;
  endfunction

  function automatic cau_sat_t sat_quot(input logic neg, input logic pov,
                                        input logic [QW-1:0] q);
    cau_sat_t    r;
    logic [16:0] qn;
    qn = 17'd0 - {1'b0, q};
    if (!neg) begin
      if (pov || q > QW'(32767)) begin
        r.v = RES_MAX;
        r.o = 1'b1;
      end else begin
        r.v = q[15:0];
        r.o = 1'b0;
      end
    end else begin
      if (pov || q > QW'(32768)) begin
        r.v = RES_MIN;
        r.o = 1'b1;
      end else begin
        r.v = qn[15:0];
        r.o = 1'b0;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/cau_div_step.sv =====
// One restoring division step on two quotient lanes sharing a divisor.
`default_nettype none
module cau_div_step
  import cau_pkg::*;
(
  input  wire cau_lane_t        lre_i,
  input  wire cau_lane_t        lim_i,
  input  wire logic [REM_W-1:0] dsh_i,
  output cau_lane_t             lre_o,
  output cau_lane_t             lim_o
);

  logic [REM_W:0] dre, dim;

  always_comb begin
    dre = {1'b0, lre_i.rem} - {1'b0, dsh_i};
    dim = {1'b0, lim_i.rem} - {1'b0, dsh_i};
    lre_o.rem = dre[REM_W] ? lre_i.rem : dre[REM_W-1:0];
    lim_o.rem = dim[REM_W] ? lim_i.rem : dim[REM_W-1:0];
    lre_o.q   = {lre_i.q[QW-2:0], ~dre[REM_W]};
    lim_o.q   = {lim_i.q[QW-2:0], ~dim[REM_W]};
  end

endmodule
`default_nettype wire

// ===== design/complex_arith_unit.sv =====
// Top level: pipelined complex add, subtract, multiply and divide in signed Q8.8.
//
//   channel | direction | handshake          | word
//   in      | input     | in_valid/in_ready  | cau_in_t  (func, a_re, a_im, b_re, b_im)
//   out     | output    | out_valid/out_ready| cau_out_t (res_re, res_im, div_zero, overflow)
//
// One word per cycle while the output is not stalled; stages: product stage, sum stage, 16 restoring
// divider stages (one quotient bit each) and the output register.
// Every operation takes the full pipeline, so results leave in order.
// Reset clears all valid bits; the pipeline holds as a whole while the output
// word waits, and empty stages never block a new word.
`default_nettype none
module complex_arith_unit
  import cau_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cau_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output cau_out_t     out_data
);

  logic adv;

  logic                v1_r;
  logic [1:0]          func1_r;
  logic signed [16:0]  lin_re1_r, lin_im1_r;
  logic signed [31:0]  p_rr1_r, p_ii1_r, p_ri1_r, p_ir1_r, p_bb1_r, p_cc1_r;

  logic        v_r   [0:QW];
  cau_side_t   side_r[0:QW];
  cau_lane_t   lre_r [0:QW];
  cau_lane_t   lim_r [0:QW];
  logic [REM_W-1:0] dsh_r[0:QW];

  logic      out_valid_r;
  cau_out_t  out_data_r;

  logic signed [16:0] lin_re_nxt, lin_im_nxt;

  cau_side_t          side_nxt;
  cau_lane_t          lre_nxt, lim_nxt;
  logic [REM_W-1:0]   dsh_nxt;

  cau_out_t  out_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    if (in_data.func == FUNC_SUB) begin
      lin_re_nxt = 17'(in_data.a_re) - 17'(in_data.b_re);
      lin_im_nxt = 17'(in_data.a_im) - 17'(in_data.b_im);
    end else begin
      lin_re_nxt = 17'(in_data.a_re) + 17'(in_data.b_re);
      lin_im_nxt = 17'(in_data.a_im) + 17'(in_data.b_im);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
    if (adv) begin
      func1_r   <= in_data.func;
      lin_re1_r <= lin_re_nxt;
      lin_im1_r <= lin_im_nxt;
      p_rr1_r   <= in_data.a_re * in_data.b_re;
      p_ii1_r   <= in_data.a_im * in_data.b_im;
      p_ri1_r   <= in_data.a_re * in_data.b_im;
      p_ir1_r   <= in_data.a_im * in_data.b_re;
      p_bb1_r   <= in_data.b_re * in_data.b_re;
      p_cc1_r   <= in_data.b_im * in_data.b_im;
    end
  end

  logic signed [32:0] mre, mim, nre, nim;
  logic signed [32:0] mre_sh, mim_sh;
  logic [31:0]        dd, nre_abs, nim_abs;
  logic [NUM_W-1:0]   nre_sc, nim_sc;
  logic [REM_W:0]     dtop, pre_re, pre_im;
  cau_sat_t           s_re, s_im;

  always_comb begin
    mre     = 33'(p_rr1_r) - 33'(p_ii1_r);
    mim     = 33'(p_ri1_r) + 33'(p_ir1_r);
    nre     = 33'(p_rr1_r) + 33'(p_ii1_r);
    nim     = 33'(p_ir1_r) - 33'(p_ri1_r);
    mre_sh  = mre >>> FRAC_BITS;
    mim_sh  = mim >>> FRAC_BITS;
    dd      = p_bb1_r + p_cc1_r;
    nre_abs = nre[32] ? 32'(-nre) : nre[31:0];
    nim_abs = nim[32] ? 32'(-nim) : nim[31:0];
    nre_sc  = NUM_W'(nre_abs) << FRAC_BITS;
    nim_sc  = NUM_W'(nim_abs) << FRAC_BITS;
    dtop    = (REM_W + 1)'(dd) << QW;
    pre_re  = (REM_W + 1)'(nre_sc) - dtop;
    pre_im  = (REM_W + 1)'(nim_sc) - dtop;
    if (func1_r == FUNC_MUL) begin
      s_re = sat34(34'(mre_sh));
      s_im = sat34(34'(mim_sh));
    end else begin
      s_re = sat34(34'(lin_re1_r));
      s_im = sat34(34'(lin_im1_r));
    end
    side_nxt.func         = func1_r;
    side_nxt.alt.res_re   = s_re.v;
    side_nxt.alt.res_im   = s_im.v;
    side_nxt.alt.div_zero = 1'b0;
    side_nxt.alt.overflow = s_re.o | s_im.o;
    side_nxt.dz           = (dd == 32'd0);
    side_nxt.neg_re       = nre[32];
    side_nxt.neg_im       = nim[32];
    side_nxt.pov_re       = ~pre_re[REM_W];
    side_nxt.pov_im       = ~pre_im[REM_W];
    lre_nxt.rem           = REM_W'(nre_sc);
    lre_nxt.q             = '0;
    lim_nxt.rem           = REM_W'(nim_sc);
    lim_nxt.q             = '0;
    dsh_nxt               = REM_W'(dd) << (QW - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= v1_r;
    end
    if (adv) begin
      side_r[0] <= side_nxt;
      lre_r[0]  <= lre_nxt;
      lim_r[0]  <= lim_nxt;
      dsh_r[0]  <= dsh_nxt;
    end
  end

  genvar j;
  generate
    for (j = 1; j <= QW; j++) begin : g_div
      cau_lane_t lre_s, lim_s;

      cau_div_step u_step (
        .lre_i (lre_r[j-1]),
        .lim_i (lim_r[j-1]),
        .dsh_i (dsh_r[j-1]),
        .lre_o (lre_s),
        .lim_o (lim_s)
      );

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[j] <= 1'b0;
        end else if (adv) begin
          v_r[j] <= v_r[j-1];
        end
        if (adv) begin
          side_r[j] <= side_r[j-1];
          lre_r[j]  <= lre_s;
          lim_r[j]  <= lim_s;
          dsh_r[j]  <= dsh_r[j-1] >> 1;
        end
      end
    end
  endgenerate

  cau_sat_t q_re, q_im;

  always_comb begin
    q_re = sat_quot(side_r[QW].neg_re, side_r[QW].pov_re, lre_r[QW].q);
    q_im = sat_quot(side_r[QW].neg_im, side_r[QW].pov_im, lim_r[QW].q);
    if (side_r[QW].func != FUNC_DIV) begin
      out_nxt = side_r[QW].alt;
    end else if (side_r[QW].dz) begin
      out_nxt.res_re   = '0;
      out_nxt.res_im   = '0;
      out_nxt.div_zero = 1'b1;
      out_nxt.overflow = 1'b0;
    end else begin
      out_nxt.res_re   = q_re.v;
      out_nxt.res_im   = q_im.v;
      out_nxt.div_zero = 1'b0;
      out_nxt.overflow = q_re.o | q_im.o;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[QW];
    end
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.div_zero |->
      out_data.res_re == 16'sd0 && out_data.res_im == 16'sd0 && !out_data.overflow)
    else $error("divide by zero word not cleared");

  a_ovf_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |->
      out_data.res_re == RES_MAX || out_data.res_re == RES_MIN ||
      out_data.res_im == RES_MAX || out_data.res_im == RES_MIN)
    else $error("overflow without a saturated part");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(v_r[0]) && $stable(v1_r))
    else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// ===== dv/tb_complex_arith_unit.sv =====
// Testbench: random and directed complex add, subtract, multiply and divide words checked in order.
`default_nettype none
module tb_complex_arith_unit;
  import cau_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  cau_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  cau_out_t out_data;

  cau_in_t  pending_words[$];
  cau_out_t expected_results[$];
  int       n_errors;
  int       n_checked;
  int       src_gap;
  int       sink_gap;
  bit       calm;
  bit       in_fire;

  complex_arith_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [15:0] clamp(input longint x, inout bit ovf);
    if (x > 32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end
    if (x < -32768) begin
      ovf = 1'b1;
      return -16'sh8000;
    end
    return x[15:0];
  endfunction

  function automatic cau_out_t complex_result(input cau_in_t w);
    cau_out_t r;
    longint   ar, ai, br, bi, re, im, den;
    bit       ovf;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    re = 0; im = 0; ovf = 1'b0;
    r = '0;
    case (w.func)
      FUNC_ADD: begin
        re = ar + br;
        im = ai + bi;
      end
      FUNC_SUB: begin
        re = ar - br;
        im = ai - bi;
      end
      FUNC_MUL: begin
        re = (ar * br - ai * bi) >>> FRAC_BITS;
        im = (ar * bi + ai * br) >>> FRAC_BITS;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          r.div_zero = 1'b1;
        end else begin
          re = ((ar * br + ai * bi) * (64'sd1 <<< FRAC_BITS)) / den;
          im = ((ai * br - ar * bi) * (64'sd1 <<< FRAC_BITS)) / den;
        end
      end
    endcase
    r.res_re   = clamp(re, ovf);
    r.res_im   = clamp(im, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  function automatic logic [15:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom_range(0, 15)) - 16'd8;
      4: return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cau_in_t make_word(input logic [1:0] f, input logic [15:0] ar,
                                        input logic [15:0] ai, input logic [15:0] br,
                                        input logic [15:0] bi);
    cau_in_t w;
    w.func = f; w.a_re = ar; w.a_im = ai; w.b_re = br; w.b_im = bi;
    return w;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (src_gap > 0) begin
      src_gap  <= src_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_words.size() > 0) begin
      in_data  <= pending_words.pop_front();
      in_valid <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 16);
    end else begin
      in_valid <= 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap  <= sink_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) sink_gap <= $urandom_range(1, 16);
    end
  end

  // monitor
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) expected_results.push_back(complex_result(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        n_errors++;
      end else begin
        cau_out_t e;
        e = expected_results.pop_front();
        n_checked++;
        if (out_data.res_re !== e.res_re) begin
          $error("res_re expected %0d actual %0d", e.res_re, out_data.res_re);
          n_errors++;
        end
        if (out_data.res_im !== e.res_im) begin
          $error("res_im expected %0d actual %0d", e.res_im, out_data.res_im);
          n_errors++;
        end
        if (out_data.div_zero !== e.div_zero) begin
          $error("div_zero expected %0b actual %0b", e.div_zero, out_data.div_zero);
          n_errors++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow expected %0b actual %0b", e.overflow, out_data.overflow);
          n_errors++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("complex_arith_unit test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; in_data = '0;
    src_gap = 0; sink_gap = 0; calm = 1'b0;
    n_errors = 0; n_checked = 0;
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    for (int f = 0; f < 4; f++) begin
      pending_words.push_back(make_word(2'(f), 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff));
      pending_words.push_back(make_word(2'(f), 16'h8000, 16'h8000, 16'h8000, 16'h8000));
      pending_words.push_back(make_word(2'(f), 16'h0100, 16'hff00, 16'h0000, 16'h0000));
      pending_words.push_back(make_word(2'(f), 16'hffff, 16'h0001, 16'h0001, 16'hffff));
      pending_words.push_back(make_word(2'(f), 16'h7fff, 16'h8000, 16'h0001, 16'h0000));
    end
    pending_words.push_back(make_word(FUNC_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    pending_words.push_back(make_word(FUNC_DIV, 16'h8000, 16'h0000, 16'hffff, 16'h0000));
    pending_words.push_back(make_word(FUNC_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000));
    pending_words.push_back(make_word(FUNC_DIV, 16'hfffd, 16'h0000, 16'h0200, 16'h0000));

    for (int i = 0; i < 750; i++) begin
      if (i == 600) begin
        wait (pending_words.size() == 0);
        calm = 1'b1;
      end
      pending_words.push_back(make_word(2'($urandom_range(0, 3)), pick_part(), pick_part(),
                                        pick_part(), pick_part()));
    end

    wait (pending_words.size() == 0 && !in_valid);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("checked %0d result words over add, subtract, multiply and divide", n_checked);
    $display("covered operand extremes, zero divisors and saturation with idling on both sides");
    if (n_errors == 0) begin
      $display("complex_arith_unit test passed");
    end else begin
      $display("complex_arith_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
